>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL. Synthesis builds define SYNTH and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, clk_i, rstn_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk_i, rstn_i, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk_i, rstn_i, prop, msg)
`define ASSERT_NEVER(lbl, clk_i, rstn_i, cond, msg)
`endif

`endif

>>> rtl/core/ils_pkg.sv
`timescale 1ns / 1ps

package ils_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;

  // Request codes.
  localparam logic [ACTION_W-1:0] ACT_READ       = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_FRONT  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_INS_BACK   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_INS_AT     = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DELETE     = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic [ACTION_W-1:0]     action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } ils_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [STATUS_W-1:0]     status;
  } ils_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SHIFT,
    S_INS_WR
  } ils_state_t;

endpackage

>>> rtl/core/ils_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module ils_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/indexed_list_store_top.sv
`timescale 1ns / 1ps

// Indexed list store. Holds an ordered list of up to DEPTH signed 32-bit values in a
// single RAM and serves one request at a time: read at a position, insert at the front,
// at the back or before a position, or delete at a position. A request is taken on a
// clock edge where start is high and busy is low, and exactly one result comes back on
// out_item, marked by out_strobe for a single cycle. The result cannot be held off, so
// the receiver must take it in the cycle it is shown. A refused request answers in the
// next cycle without going busy; a read is busy in S_RD_WAIT while the RAM's registered
// data comes back. An insert or a delete that has to move later entries keeps busy high
// while the RAM moves them one entry per cycle: each S_SHIFT cycle reads the next entry
// to move while the write port stores the one read the cycle before, and a last S_SHIFT
// cycle stores the final entry. An insert then writes the new value in S_INS_WR. The
// result is shown in the same cycle that busy falls. An append moves nothing and is
// busy only in S_INS_WR; a delete of the last entry moves nothing, never goes busy and
// answers in the next cycle. On a read miss, and for every request other than a read,
// read_value carries all ones; the status tells done, position out of range (also any
// unknown request code), or store full. Reset empties the list at once; the RAM
// contents are left as they are, since only entries below the count are ever read.
module indexed_list_store_top
  import ils_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ils_in_t  in_item,
  output logic     out_strobe,
  output ils_out_t out_item
);

`include "assert_macros.svh"

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  // Common width for comparing a request position with the count.
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  // Control state.
  ils_state_t    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] left_r, left_nxt;    // entries still to be read during a shift
  logic          pend_r, pend_nxt;    // a read is in flight and must be written back
  logic          out_strobe_r, out_strobe_nxt;

  // Work registers of the request under way.
  logic [AW-1:0]          src_r, src_nxt;
  logic [AW-1:0]          dst_r, dst_nxt;
  logic [AW-1:0]          ins_pos_r, ins_pos_nxt;
  logic                   is_ins_r, is_ins_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  ils_out_t               out_r, out_nxt;

  // RAM port signals.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  // Request decode.
  logic            accept;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] ins_pos_ext;
  logic            is_full;

  assign accept  = start && (state_r == S_IDLE);
  assign pos_ext = CMPW'(in_item.position);
  assign cnt_ext = CMPW'(count_r);
  assign is_full = (count_r == CW'(DEPTH));

  // Position at which an insert request places its value.
  always_comb begin
    case (in_item.action)
      ACT_INS_FRONT: ins_pos_ext = '0;
      ACT_INS_BACK:  ins_pos_ext = cnt_ext;
      default:       ins_pos_ext = pos_ext;
    endcase
  end

  ils_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      left_r       <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      left_r       <= left_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    ins_pos_r <= ins_pos_nxt;
    is_ins_r  <= is_ins_nxt;
    val_r     <= val_nxt;
    out_r     <= out_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    left_nxt       = left_r;
    pend_nxt       = pend_r;
    out_strobe_nxt = 1'b0;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    ins_pos_nxt    = ins_pos_r;
    is_ins_nxt     = is_ins_r;
    val_nxt        = val_r;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_waddr      = dst_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = src_r;

    case (state_r)
      S_IDLE: begin
        ram_raddr = pos_ext[AW-1:0];
        if (accept) begin
          out_nxt.read_value = MISS_VALUE;
          out_nxt.status     = ST_DONE;
          val_nxt            = in_item.value;
          case (in_item.action)
            ACT_READ: begin
              if (pos_ext < cnt_ext) begin
                state_nxt = S_RD_WAIT;
              end else begin
                out_nxt.status = ST_RANGE;
                out_strobe_nxt = 1'b1;
              end
            end
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
              if (ins_pos_ext > cnt_ext) begin
                out_nxt.status = ST_RANGE;
                out_strobe_nxt = 1'b1;
              end else if (is_full) begin
                out_nxt.status = ST_FULL;
                out_strobe_nxt = 1'b1;
              end else begin
                // Move entries count-1 down to pos up by one, then write the value.
                count_nxt   = count_r + CW'(1);
                is_ins_nxt  = 1'b1;
                ins_pos_nxt = ins_pos_ext[AW-1:0];
                left_nxt    = CW'(cnt_ext - ins_pos_ext);
                src_nxt     = AW'(cnt_ext - CMPW'(1));
                pend_nxt    = 1'b0;
                state_nxt   = (cnt_ext == ins_pos_ext) ? S_INS_WR : S_SHIFT;
              end
            end
            ACT_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                out_nxt.status = ST_RANGE;
                out_strobe_nxt = 1'b1;
              end else begin
                // Move entries pos+1 up to count-1 down by one.
                count_nxt  = count_r - CW'(1);
                is_ins_nxt = 1'b0;
                left_nxt   = CW'(cnt_ext - pos_ext - CMPW'(1));
                src_nxt    = AW'(pos_ext + CMPW'(1));
                pend_nxt   = 1'b0;
                if (pos_ext + CMPW'(1) == cnt_ext) begin
                  out_strobe_nxt = 1'b1;
                end else begin
                  state_nxt = S_SHIFT;
                end
              end
            end
            default: begin
              out_nxt.status = ST_RANGE;
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      S_RD_WAIT: begin
        out_nxt.read_value = ram_rdata;
        out_nxt.status     = ST_DONE;
        out_strobe_nxt     = 1'b1;
        state_nxt          = S_IDLE;
      end

      S_SHIFT: begin
        // Write back the entry read last cycle while reading the next one.
        ram_we = pend_r;
        if (left_r != '0) begin
          pend_nxt = 1'b1;
          left_nxt = left_r - CW'(1);
          if (is_ins_r) begin
            dst_nxt = src_r + AW'(1);
            src_nxt = src_r - AW'(1);
          end else begin
            dst_nxt = src_r - AW'(1);
            src_nxt = src_r + AW'(1);
          end
        end else begin
          pend_nxt = 1'b0;
          if (is_ins_r) begin
            state_nxt = S_INS_WR;
          end else begin
            out_strobe_nxt = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end

      S_INS_WR: begin
        ram_we         = 1'b1;
        ram_waddr      = ins_pos_r;
        ram_wdata      = val_r;
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  // The count never exceeds the capacity of the store.
  `ASSERT_NEVER(a_count_bound, clk, rst_n, count_r > CW'(DEPTH), "count exceeds depth")
  // A result is only shown once the work on its request has ended.
  `ASSERT_PROP(a_strobe_idle, clk, rst_n, out_strobe |-> !busy, "result while busy")
  // Every accepted request either keeps the block busy or answers in the next cycle.
  `ASSERT_PROP(a_accept_answer, clk, rst_n, (start && !busy) |=> (busy || out_strobe),
               "accepted request lost")
  // The count moves only on an accepted request.
  `ASSERT_PROP(a_count_hold, clk, rst_n, !(start && !busy) |=> $stable(count_r),
               "count changed without a request")

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the indexed list store.
module tb_top;
  import ils_pkg::*;

  localparam int unsigned DEPTH          = 64;
  localparam int unsigned RANDOM_ITEMS   = 1350;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned DRAIN_CYCLES   = 12;

  // Codes outside the defined set of requests.
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN_LO  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN_MID = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN_HI  = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic [POS_W-1:0]        POS_TOP = '1;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  ils_in_t  in_item = '0;
  logic     out_strobe;
  ils_out_t out_item;

  // Side information that travels with each request: when set, the row of the directed
  // table carries its own expected result, which then replaces the predicted one.
  logic     row_chk = 1'b0;
  ils_out_t row_want = '0;

  indexed_list_store_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------
  // Shadow copy of the list. It is updated at the edge where a request transfer takes
  // place, so its contents always match what the store holds once all accepted work has
  // been done.
  // ---------------------------------------------------------------------------------
  logic signed [VAL_W-1:0] shadow_list [DEPTH];
  int unsigned             shadow_count = 0;

  function automatic ils_out_t apply_to_shadow(ils_in_t req);
    ils_out_t    res;
    int unsigned pos;
    int unsigned ins_pos;
    bit          is_ins;
    int unsigned i;
    res.read_value = MISS_VALUE;
    res.status = ST_RANGE;
    pos = 32'(req.position);
    ins_pos = 0;
    is_ins = 1'b0;
    case (req.action)
      ACT_READ: begin
        if (pos < shadow_count) begin
          res.read_value = shadow_list[pos];
          res.status = ST_DONE;
        end
      end
      ACT_INS_FRONT: begin
        is_ins = 1'b1;
        ins_pos = 0;
      end
      ACT_INS_BACK: begin
        is_ins = 1'b1;
        ins_pos = shadow_count;
      end
      ACT_INS_AT: begin
        is_ins = 1'b1;
        ins_pos = pos;
      end
      ACT_DELETE: begin
        if (pos < shadow_count) begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_count--;
          res.status = ST_DONE;
        end
      end
      default: begin
        // Unknown codes leave the list alone and report out of range.
      end
    endcase
    // The position check comes before the full check, so a bad position on a full
    // store still reports out of range.
    if (is_ins) begin
      if (ins_pos > shadow_count) begin
        res.status = ST_RANGE;
      end else if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        for (i = shadow_count; i > ins_pos; i--) shadow_list[i] = shadow_list[i - 1];
        shadow_list[ins_pos] = req.value;
        shadow_count++;
        res.status = ST_DONE;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------------
  // Result checking. Both the request and the result side are sampled at the rising
  // edge, before the edge's own updates land, so the values seen are those transferred.
  // The result is checked before any new request of the same edge is predicted, since a
  // result can never belong to a request taken at the very same edge.
  // ---------------------------------------------------------------------------------
  ils_out_t    awaited_results [$];
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned requests_taken = 0;
  int unsigned full_hits = 0;
  int unsigned range_hits = 0;
  int unsigned peak_count = 0;

  always @(posedge clk) begin
    ils_out_t want;
    ils_out_t predicted;
    if (rst_n) begin
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result with nothing outstanding: value %h status %0d",
                     $realtime, out_item.read_value, out_item.status);
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (out_item.status == ST_FULL) full_hits++;
          if (out_item.status == ST_RANGE) range_hits++;
          if (out_item.read_value !== want.read_value || out_item.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: result mismatch: expected value %h status %0d, got %h status %0d",
                       $realtime, want.read_value, want.status,
                       out_item.read_value, out_item.status);
          end
        end
      end
      if (start && !busy) begin
        predicted = apply_to_shadow(in_item);
        awaited_results.push_back(row_chk ? row_want : predicted);
        requests_taken++;
        if (shadow_count > peak_count) peak_count = shadow_count;
      end
    end
  end

  // The watchdog counts cycles in which no transfer happens on either side. The longest
  // legal wait is a full-length shift plus the longest sender gap, far below the limit.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------------
  typedef struct packed {
    logic [ACTION_W-1:0]     act;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    logic [7:0]              reps;
    logic                    chk;
    logic signed [VAL_W-1:0] rv;
    logic [STATUS_W-1:0]     st;
  } stim_row_t;

  localparam int unsigned N_ROWS = 26;

  // Directed rows. Rows with chk set carry an expected result that is plain from the
  // request alone; the rest are left to the predictor. A row with reps above one is
  // issued that many times, its value stepping by one each time.
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // Empty store: reads, deletes and positional inserts all miss.
    '{ACT_READ,        7'd0,   32'sd0,   8'd1,  1'b1, MISS_VALUE, ST_RANGE},
    '{ACT_DELETE,      7'd0,   32'sd0,   8'd1,  1'b1, MISS_VALUE, ST_RANGE},
    '{ACT_INS_AT,      7'd1,   32'sd5,   8'd1,  1'b1, MISS_VALUE, ST_RANGE},
    '{ACT_READ,        POS_TOP, 32'sd0,  8'd1,  1'b1, MISS_VALUE, ST_RANGE},
    // Unknown request codes leave the list alone and report out of range.
    '{ACT_UNKNOWN_LO,  7'd0,   VAL_MAX,  8'd1,  1'b1, MISS_VALUE, ST_RANGE},
    '{ACT_UNKNOWN_MID, 7'd64,  VAL_MIN,  8'd1,  1'b1, MISS_VALUE, ST_RANGE},
    '{ACT_UNKNOWN_HI,  POS_TOP, -32'sd1, 8'd1,  1'b1, MISS_VALUE, ST_RANGE},
    // Each kind of insert, with the extreme values.
    '{ACT_INS_AT,      7'd0,   VAL_MIN,  8'd1,  1'b1, MISS_VALUE, ST_DONE},
    '{ACT_INS_FRONT,   7'd0,   VAL_MAX,  8'd1,  1'b1, MISS_VALUE, ST_DONE},
    '{ACT_INS_BACK,    POS_TOP, 32'sd0,  8'd1,  1'b1, MISS_VALUE, ST_DONE},
    '{ACT_READ,        7'd0,   32'sd0,   8'd1,  1'b0, MISS_VALUE, ST_DONE},
    '{ACT_READ,        7'd1,   32'sd0,   8'd1,  1'b0, MISS_VALUE, ST_DONE},
    '{ACT_READ,        7'd2,   32'sd0,   8'd1,  1'b0, MISS_VALUE, ST_DONE},
    '{ACT_READ,        7'd3,   32'sd0,   8'd1,  1'b1, MISS_VALUE, ST_RANGE},
    // A position equal to the count appends; then an insert in the middle.
    '{ACT_INS_AT,      7'd3,   32'sd1,   8'd1,  1'b1, MISS_VALUE, ST_DONE},
    '{ACT_INS_AT,      7'd1,   32'sh5A5A_5A5A, 8'd1, 1'b0, MISS_VALUE, ST_DONE},
    '{ACT_DELETE,      7'd2,   32'sd0,   8'd1,  1'b0, MISS_VALUE, ST_DONE},
    '{ACT_DELETE,      7'd4,   32'sd0,   8'd1,  1'b1, MISS_VALUE, ST_RANGE},
    // Fill to the top, then every kind of insert into the full store.
    '{ACT_INS_BACK,    7'd0,   32'sh0000_1000, 8'd60, 1'b0, MISS_VALUE, ST_DONE},
    '{ACT_INS_FRONT,   7'd0,   32'sd9,   8'd1,  1'b1, MISS_VALUE, ST_FULL},
    '{ACT_INS_BACK,    7'd0,   32'sd9,   8'd1,  1'b1, MISS_VALUE, ST_FULL},
    '{ACT_INS_AT,      7'd64,  32'sd9,   8'd1,  1'b1, MISS_VALUE, ST_FULL},
    '{ACT_INS_AT,      7'd65,  32'sd9,   8'd1,  1'b1, MISS_VALUE, ST_RANGE},
    '{ACT_READ,        7'd63,  32'sd0,   8'd1,  1'b0, MISS_VALUE, ST_DONE},
    // Empty it again from the front, which moves the most entries each time.
    '{ACT_DELETE,      7'd0,   32'sd0,   8'd64, 1'b0, MISS_VALUE, ST_DONE},
    '{ACT_READ,        7'd0,   32'sd0,   8'd1,  1'b1, MISS_VALUE, ST_RANGE}
  };

  // Sender idling: mostly back to back, sometimes short gaps and now and then a long
  // one. While a burst is running, no gaps are inserted at all.
  bit burst_mode = 1'b0;

  function automatic int unsigned sender_gap();
    int unsigned r;
    if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VAL_W-1:0] random_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return VAL_MIN;
    if (r < 12) return VAL_MAX;
    if (r < 16) return -32'sd1;
    if (r < 20) return 32'sd0;
    return $urandom;
  endfunction

  // Positions mostly stay within the list (or one past it), so that real work is done;
  // the rest range over the whole field.
  function automatic logic [POS_W-1:0] random_position(int unsigned upper);
    if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, upper));
    return POS_W'($urandom_range(0, 2 ** POS_W - 1));
  endfunction

  // Random requests follow a fill phase and a drain phase in turn, so that the list
  // sweeps its whole range of lengths, spending time both full and empty.
  bit filling = 1'b1;

  function automatic ils_in_t random_request();
    ils_in_t     req;
    int unsigned r;
    int unsigned ins_share;
    if (shadow_count >= DEPTH && $urandom_range(0, 5) == 0) filling = 1'b0;
    if (shadow_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
    if ($urandom_range(0, 149) == 0) filling = !filling;
    ins_share = filling ? 55 : 20;
    req.value = random_value();
    req.position = random_position(shadow_count);
    r = $urandom_range(0, 99);
    if (r < 3) begin
      req.action = ACT_UNKNOWN_LO + ACTION_W'($urandom_range(0, 2));
    end else if (r < 23) begin
      req.action = ACT_READ;
    end else if (r < 23 + ins_share) begin
      case ($urandom_range(0, 2))
        0:       req.action = ACT_INS_FRONT;
        1:       req.action = ACT_INS_BACK;
        default: req.action = ACT_INS_AT;
      endcase
    end else begin
      req.action = ACT_DELETE;
      if (shadow_count > 0 && $urandom_range(0, 9) != 0)
        req.position = POS_W'($urandom_range(0, shadow_count - 1));
    end
    return req;
  endfunction

  // Offers one request and returns once it has been taken. start is only lowered when
  // a gap is wanted, so a back-to-back request keeps it high without a glitch.
  task automatic offer(ils_in_t req, logic chk, ils_out_t want);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= req;
    row_chk <= chk;
    row_want <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    ils_in_t     req;
    ils_out_t    want;
    int unsigned row;
    int unsigned k;
    int unsigned n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < N_ROWS; row++) begin
      for (k = 0; k < DIRECTED[row].reps; k++) begin
        req.action = DIRECTED[row].act;
        req.position = DIRECTED[row].pos;
        req.value = DIRECTED[row].val + k;
        want.read_value = DIRECTED[row].rv;
        want.status = DIRECTED[row].st;
        offer(req, DIRECTED[row].chk, want);
      end
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      offer(random_request(), 1'b0, '0);
    end
    start <= 1'b0;

    // Wait for the last results, then watch a little longer for any stray strobe.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Requests transferred: %0d, results checked: %0d, mismatches: %0d.",
             requests_taken, results_checked, mismatch_count);
    $display("Out-of-range results: %0d, full-store results: %0d, longest list: %0d.",
             range_hits, full_hits, peak_count);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
